@@ rtl/eligibility_trace_table_defines.svh @@
`ifndef ELIGIBILITY_TRACE_TABLE_DEFINES_SVH
`define ELIGIBILITY_TRACE_TABLE_DEFINES_SVH

// same-cycle check
`define ETT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("eligibility trace table check failed");

// next-cycle check
`define ETT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eligibility trace table check failed");

`endif

@@ rtl/ett_pkg.sv @@
`timescale 1ns / 1ps

package ett_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int STATE_BITS  = 16;
    localparam int ACTION_BITS = 8;
    localparam int KEY_W       = STATE_BITS + ACTION_BITS;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int TRACE_W     = 16;
    localparam int ENTRY_W     = KEY_W + TRACE_W;
    localparam int GAIN_W      = 32;
    localparam int PROD_W      = GAIN_W + TRACE_W;

    localparam logic [TRACE_W-1:0] ONE_Q12   = 16'd4096;
    localparam logic [TRACE_W-1:0] TRACE_MAX = 16'hFFFF;

    localparam logic [2:0] OP_VISIT  = 3'd0;
    localparam logic [2:0] OP_DECAY  = 3'd1;
    localparam logic [2:0] OP_LOOKUP = 3'd2;
    localparam logic [2:0] OP_APPLY  = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [1:0] MODE_ACCUM   = 2'd0;
    localparam logic [1:0] MODE_REPLACE = 2'd1;
    localparam logic [1:0] MODE_DUTCH   = 2'd2;

    localparam logic [2:0] REG_TRACE_MODE = 3'd0;
    localparam logic [2:0] REG_LAMBDA     = 3'd1;
    localparam logic [2:0] REG_DISCOUNT   = 3'd2;
    localparam logic [2:0] REG_THRESHOLD  = 3'd3;
    localparam logic [2:0] REG_CAPACITY   = 3'd4;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [15:0]        state_key;
        logic [7:0]         action_key;
        logic signed [15:0] err_term;
        logic [15:0]        step_size;
        logic [6:0]         max_updates;
    } command_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               found;
        logic [6:0]         entry_count;
        logic               dropped;
        logic               last;
    } result_t;

    typedef struct packed {
        logic latch;
        logic setup;
        logic mul;
        logic act;
        logic fin;
    } ctrl_cmd_t;

    typedef struct packed {
        logic empty;
        logic done;
    } ctrl_stat_t;

endpackage

@@ rtl/eligibility_trace_table.sv @@
`timescale 1ns / 1ps

// Table of up to 64 eligibility traces keyed by state and action. A command is
// taken when start is high and busy is low; each result word appears on result
// for one cycle with strobe high and must be taken then, since the block cannot
// be stalled. Visit, lookup, decay and apply walk the stored entries through the
// table RAM, each entry going through read, multiply and update states in turn;
// clear, unused codes and walks over an empty table go through the setup and
// finish states only. Apply emits one word per entry walked. Configuration
// writes are always ready and are meant to be made while busy is low.
module eligibility_trace_table (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ett_pkg::command_t command,
    output logic              busy,
    output ett_pkg::result_t  result,
    output logic              strobe,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [16:0]       cfg_data
);

    ett_pkg::ctrl_cmd_t  cmd;
    ett_pkg::ctrl_stat_t stat;
    logic                busy_int;

    ett_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy_int)
    );

    ett_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .command   (command),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result),
        .strobe    (strobe)
    );

    assign busy      = busy_int;
    assign cfg_ready = 1'b1;

endmodule

@@ rtl/ett_ram.sv @@
`timescale 1ns / 1ps

module ett_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/ett_ctrl.sv @@
`timescale 1ns / 1ps

module ett_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  ett_pkg::ctrl_stat_t stat,
    output ett_pkg::ctrl_cmd_t  cmd,
    output logic               busy
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SETUP = 6'b000010,
        S_RD    = 6'b000100,
        S_MUL   = 6'b001000,
        S_ACT   = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (start) state_next = S_SETUP;
            S_SETUP: state_next = stat.empty ? S_FIN : S_RD;
            S_RD:    state_next = S_MUL;
            S_MUL:   state_next = S_ACT;
            S_ACT:   state_next = stat.done ? S_IDLE : S_RD;
            S_FIN:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign cmd.latch = (state_reg == S_IDLE) && start;
    assign cmd.setup = (state_reg == S_SETUP);
    assign cmd.mul   = (state_reg == S_MUL);
    assign cmd.act   = (state_reg == S_ACT);
    assign cmd.fin   = (state_reg == S_FIN);

endmodule

@@ rtl/ett_datapath.sv @@
`timescale 1ns / 1ps
`include "eligibility_trace_table_defines.svh"

module ett_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  ett_pkg::command_t   command,
    input  ett_pkg::ctrl_cmd_t  cmd,
    output ett_pkg::ctrl_stat_t stat,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [16:0]         cfg_data,
    output ett_pkg::result_t    result,
    output logic                strobe
);

    localparam int IW = ett_pkg::IDX_W;
    localparam int CW = ett_pkg::CNT_W;
    localparam int TW = ett_pkg::TRACE_W;
    localparam int EW = ett_pkg::ENTRY_W;
    localparam int KW = ett_pkg::KEY_W;

    // configuration
    logic [1:0]  mode_reg;
    logic [16:0] lambda_reg;
    logic [16:0] discount_reg;
    logic [15:0] thresh_reg;
    logic [6:0]  cap_reg;

    ett_pkg::command_t cmd_reg;
    logic [ett_pkg::GAIN_W-1:0] gain_reg, gain_next;
    logic [ett_pkg::PROD_W-1:0] prod_reg;
    logic [EW-1:0] entry_reg;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] w_reg, w_next;
    logic [CW-1:0] count_reg, count_next;
    ett_pkg::result_t res_reg, res_next;
    logic strobe_reg, strobe_next;

    logic          we;
    logic [IW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic [EW-1:0] rdata;

    logic [KW-1:0] key_in;
    logic [KW-1:0] e_key;
    logic [TW-1:0] e_tr;
    logic          hit;
    logic          is_last;
    logic          cap_ok;
    logic          is_apply;
    logic          is_walk;
    logic          td_neg;
    logic [16:0]   td_mag;
    logic [16:0]   mul_a;
    logic [16:0]   mul_b;
    logic [33:0]   setup_prod;
    logic [CW-1:0] n_calc;
    logic [16:0]   acc_sum;
    logic [31:0]   dutch_sum;
    logic [TW-1:0] hit_trace;
    logic [TW-1:0] decay_trace;
    logic [35:0]   mag;
    logic [31:0]   mag_sat;
    logic [31:0]   upd_value;

    ett_ram #(
        .WIDTH(EW),
        .DEPTH(ett_pkg::MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (i_reg[IW-1:0]),
        .rdata (rdata)
    );

    assign key_in = {cmd_reg.state_key[ett_pkg::STATE_BITS-1:0],
                     cmd_reg.action_key[ett_pkg::ACTION_BITS-1:0]};
    assign e_key   = entry_reg[EW-1:TW];
    assign e_tr    = entry_reg[TW-1:0];
    assign hit     = (e_key == key_in);
    assign is_last = (CW'(i_reg + 1'b1) == n_reg);
    assign cap_ok  = ({1'b0, count_reg} < {1'b0, cap_reg})
                     && (count_reg < CW'(ett_pkg::MAX_ENTRIES));
    assign is_apply = (cmd_reg.opcode == ett_pkg::OP_APPLY);
    assign is_walk  = cmd_reg.opcode inside {ett_pkg::OP_VISIT, ett_pkg::OP_DECAY,
                                             ett_pkg::OP_LOOKUP, ett_pkg::OP_APPLY};

    // gain setup: lr*|td| for apply, gamma*lambda for decay
    assign td_neg     = cmd_reg.err_term[15];
    assign td_mag     = td_neg ? (17'h10000 - {1'b0, cmd_reg.err_term})
                               : {1'b0, cmd_reg.err_term};
    assign mul_a      = is_apply ? {1'b0, cmd_reg.step_size} : discount_reg;
    assign mul_b      = is_apply ? td_mag : lambda_reg;
    assign setup_prod = mul_a * mul_b;
    assign n_calc     = (is_apply && ({1'b0, cmd_reg.max_updates} < {1'b0, count_reg}))
                        ? CW'(cmd_reg.max_updates) : count_reg;

    always_comb
    begin
        if (is_apply)
        begin
            gain_next = setup_prod[31:0];
        end
        else if (cmd_reg.opcode == ett_pkg::OP_DECAY)
        begin
            gain_next = 32'(setup_prod[33:16]);
        end
        else
        begin
            gain_next = 32'(lambda_reg);
        end
    end

    // per entry arithmetic
    assign acc_sum   = {1'b0, e_tr} + 17'(ett_pkg::ONE_Q12);
    assign dutch_sum = prod_reg[47:16] + 32'(ett_pkg::ONE_Q12);

    always_comb
    begin
        case (mode_reg)
            ett_pkg::MODE_ACCUM:
                hit_trace = acc_sum[16] ? ett_pkg::TRACE_MAX : acc_sum[15:0];
            ett_pkg::MODE_REPLACE:
                hit_trace = ett_pkg::ONE_Q12;
            ett_pkg::MODE_DUTCH:
                hit_trace = (dutch_sum > 32'(ett_pkg::TRACE_MAX)) ? ett_pkg::TRACE_MAX
                                                                  : dutch_sum[15:0];
            default:
                hit_trace = e_tr;
        endcase
    end

    assign decay_trace = (prod_reg[47:32] != 16'd0) ? ett_pkg::TRACE_MAX : prod_reg[31:16];
    assign mag         = prod_reg[47:12];

    always_comb
    begin
        if (td_neg)
        begin
            mag_sat   = (mag > 36'h80000000) ? 32'h80000000 : mag[31:0];
            upd_value = 32'd0 - mag_sat;
        end
        else
        begin
            mag_sat   = (mag > 36'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
            upd_value = mag_sat;
        end
    end

    always_comb
    begin
        we          = 1'b0;
        waddr       = count_reg[IW-1:0];
        wdata       = {key_in, ett_pkg::ONE_Q12};
        n_next      = n_reg;
        i_next      = i_reg;
        w_next      = w_reg;
        count_next  = count_reg;
        res_next    = res_reg;
        strobe_next = 1'b0;
        stat.empty  = (n_calc == '0) || !is_walk;
        stat.done   = 1'b0;

        if (cmd.setup)
        begin
            n_next = n_calc;
            i_next = '0;
            w_next = '0;
        end

        if (cmd.act)
        begin
            i_next = CW'(i_reg + 1'b1);
            case (cmd_reg.opcode)
                ett_pkg::OP_VISIT:
                begin
                    if (hit)
                    begin
                        we          = 1'b1;
                        waddr       = i_reg[IW-1:0];
                        wdata       = {e_key, hit_trace};
                        stat.done   = 1'b1;
                        strobe_next = 1'b1;
                        res_next    = '{value: '0, found: 1'b1, entry_count: count_reg,
                                        dropped: 1'b0, last: 1'b1};
                    end
                    else if (is_last)
                    begin
                        stat.done   = 1'b1;
                        strobe_next = 1'b1;
                        we          = cap_ok;
                        count_next  = cap_ok ? CW'(count_reg + 1'b1) : count_reg;
                        res_next    = '{value: '0, found: 1'b0, entry_count: count_next,
                                        dropped: !cap_ok, last: 1'b1};
                    end
                end
                ett_pkg::OP_LOOKUP:
                begin
                    if (hit || is_last)
                    begin
                        stat.done   = 1'b1;
                        strobe_next = 1'b1;
                        res_next    = '{value: hit ? 32'(e_tr) : 32'd0, found: hit,
                                        entry_count: count_reg, dropped: 1'b0, last: 1'b1};
                    end
                end
                ett_pkg::OP_DECAY:
                begin
                    if (decay_trace >= thresh_reg)
                    begin
                        we     = 1'b1;
                        waddr  = w_reg[IW-1:0];
                        wdata  = {e_key, decay_trace};
                        w_next = CW'(w_reg + 1'b1);
                    end
                    if (is_last)
                    begin
                        stat.done   = 1'b1;
                        strobe_next = 1'b1;
                        count_next  = w_next;
                        res_next    = '{value: '0, found: 1'b0, entry_count: w_next,
                                        dropped: 1'b0, last: 1'b1};
                    end
                end
                ett_pkg::OP_APPLY:
                begin
                    stat.done   = is_last;
                    strobe_next = 1'b1;
                    res_next    = '{value: upd_value, found: 1'b1, entry_count: count_reg,
                                    dropped: 1'b0, last: is_last};
                end
                default:
                begin
                    stat.done   = 1'b1;
                    strobe_next = 1'b1;
                    res_next    = '{value: '0, found: 1'b0, entry_count: count_reg,
                                    dropped: 1'b0, last: 1'b1};
                end
            endcase
        end

        if (cmd.fin)
        begin
            strobe_next = 1'b1;
            case (cmd_reg.opcode)
                ett_pkg::OP_VISIT:
                begin
                    we         = cap_ok;
                    count_next = cap_ok ? CW'(count_reg + 1'b1) : count_reg;
                    res_next   = '{value: '0, found: 1'b0, entry_count: count_next,
                                   dropped: !cap_ok, last: 1'b1};
                end
                ett_pkg::OP_CLEAR:
                begin
                    count_next = '0;
                    res_next   = '{value: '0, found: 1'b0, entry_count: '0,
                                   dropped: 1'b0, last: 1'b1};
                end
                default:
                begin
                    res_next   = '{value: '0, found: 1'b0, entry_count: count_reg,
                                   dropped: 1'b0, last: 1'b1};
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= ett_pkg::MODE_REPLACE;
            lambda_reg   <= 17'd58982;
            discount_reg <= 17'd64880;
            thresh_reg   <= 16'd41;
            cap_reg      <= 7'd64;
            count_reg    <= '0;
            strobe_reg   <= 1'b0;
            n_reg        <= '0;
            i_reg        <= '0;
            w_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ett_pkg::REG_TRACE_MODE: mode_reg     <= cfg_data[1:0];
                    ett_pkg::REG_LAMBDA:     lambda_reg   <= cfg_data;
                    ett_pkg::REG_DISCOUNT:   discount_reg <= cfg_data;
                    ett_pkg::REG_THRESHOLD:  thresh_reg   <= cfg_data[15:0];
                    ett_pkg::REG_CAPACITY:   cap_reg      <= cfg_data[6:0];
                    default:                 ;
                endcase
            end
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
            n_reg      <= n_next;
            i_reg      <= i_next;
            w_reg      <= w_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_reg <= command;
        end
        if (cmd.setup)
        begin
            gain_reg <= gain_next;
        end
        if (cmd.mul)
        begin
            entry_reg <= rdata;
            prod_reg  <= gain_reg * rdata[TW-1:0];
        end
        res_reg <= res_next;
    end

    assign result = res_reg;
    assign strobe = strobe_reg;

    `ETT_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CW'(ett_pkg::MAX_ENTRIES))
    `ETT_ASSERT_NOW(a_compact_order, cmd.act, w_reg <= i_reg)
    `ETT_ASSERT_NOW(a_walk_bound, cmd.act, i_reg < n_reg)
    `ETT_ASSERT_NEXT(a_single_result, cmd.fin, strobe_reg && res_reg.last)

endmodule
